>>> rtl/dsp_pkg.sv
package dsp_pkg;

    // result width of the divisor sum and its saturation value
    localparam int SUM_W = 23;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // controller states: table build after reset, then factoring
    typedef enum logic [3:0] {
        S_INIT_RD,
        S_INIT_CHK,
        S_INIT_DIV,
        S_IDLE,
        S_RD,
        S_CHK,
        S_DIV,
        S_DIVGO,
        S_MUL,
        S_TAIL,
        S_TMUL,
        S_OUT
    } state_t;

    // divider status back to the controller
    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_stat_t;

endpackage

>>> rtl/dsp_ram.sv
module dsp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dsp_div.sv
module dsp_div import dsp_pkg::*; #(
    parameter int DIV_W = 20,
    parameter int D_W   = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [D_W-1:0]   divisor,
    output div_stat_t        stat,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [D_W-1:0]   part_reg, part_next;
    logic [D_W-1:0]   den_reg, den_next;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial     = {part_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        part_next = part_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            part_next = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            part_next = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and partial remainder registers
    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        part_reg <= part_next;
        den_reg  <= den_next;
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (part_reg == '0);
    assign quotient      = quo_reg;

endmodule

>>> rtl/dsp_mul.sv
module dsp_mul #(
    parameter int A_W = 23,
    parameter int B_W = 21
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [A_W-1:0] product
);

    localparam int CNT_W = $clog2(B_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(B_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [A_W-1:0]   acc_reg, acc_next;
    logic [A_W-1:0]   ash_reg, ash_next;
    logic [B_W-1:0]   bsh_reg, bsh_next;

    // shift-and-add, one multiplier bit per cycle, product kept modulo 2^A_W
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        ash_next  = ash_reg;
        bsh_next  = bsh_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            ash_next  = a;
            bsh_next  = b;
        end
        else if (busy_reg)
        begin
            if (bsh_reg[0])
            begin
                acc_next = acc_reg + ash_reg;
            end
            ash_next = {ash_reg[A_W-2:0], 1'b0};
            bsh_next = {1'b0, bsh_reg[B_W-1:1]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ash_reg <= ash_next;
        bsh_reg <= bsh_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> rtl/divisor_sum_perfect_test.sv
// channel  | ports                       | timing
// ---------+-----------------------------+---------------------------------------
// request  | start, value                | taken when start is high and busy low
// result   | done, divisor_sum, is_perfect | done high for one cycle per request
//
// After reset the prime table is built by trial division of each candidate
// below PRIME_LIMIT over the primes found so far; busy stays high meanwhile.
// A request then runs the bit-serial divider once for every table prime p
// with p*p not above the remainder, once more for each further division by
// a prime factor, and the serial multiplier once per distinct prime factor.
// The result cannot be held off: it is shown for one cycle, and a new request
// may be taken in that same cycle.
module divisor_sum_perfect_test import dsp_pkg::*; #(
    parameter int VALUE_BITS  = 20,
    parameter int PRIME_LIMIT = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  busy,
    output logic                  done,
    output logic [SUM_W-1:0]      divisor_sum,
    output logic                  is_perfect
);

    localparam int PRIME_BITS = $clog2(PRIME_LIMIT);
    localparam int DIV_W      = (VALUE_BITS > PRIME_BITS) ? VALUE_BITS : PRIME_BITS;
    localparam int SIGMA_W    = VALUE_BITS + 3;
    localparam int GEO_W      = VALUE_BITS + 1;
    localparam int SQ_W       = (2 * PRIME_BITS > VALUE_BITS) ? 2 * PRIME_BITS : VALUE_BITS;
    localparam int CMP_W      = (SIGMA_W > SUM_W) ? SIGMA_W : SUM_W;
    localparam int TAB_DEPTH  = PRIME_LIMIT / 2;
    localparam int ADDR_W     = $clog2(TAB_DEPTH);
    localparam int CNT_W      = $clog2(TAB_DEPTH + 1);
    localparam logic [PRIME_BITS-1:0] CAND_LAST = PRIME_BITS'(PRIME_LIMIT - 1);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [PRIME_BITS-1:0] cand_reg, cand_next;
    logic                  done_reg, done_next;

    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic [SIGMA_W-1:0]    sigma_reg, sigma_next;
    logic [GEO_W-1:0]      geo_reg, geo_next;
    logic [PRIME_BITS-1:0] p_reg, p_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  perf_reg, perf_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [PRIME_BITS-1:0] ram_rdata;

    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [PRIME_BITS-1:0] div_divisor;
    div_stat_t             div_stat;
    logic [DIV_W-1:0]      div_quo;

    logic                  mul_start;
    logic [GEO_W-1:0]      mul_b;
    logic                  mul_done;
    logic [SIGMA_W-1:0]    mul_prod;

    logic [2*PRIME_BITS-1:0] psq;
    logic                    k_at_end;
    logic                    init_phase;

    // prime table
    dsp_ram #(
        .WIDTH (PRIME_BITS),
        .DEPTH (TAB_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cand_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // trial divider
    dsp_div #(
        .DIV_W (DIV_W),
        .D_W   (PRIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // running product multiplier
    dsp_mul #(
        .A_W (SIGMA_W),
        .B_W (GEO_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (sigma_reg),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    // table addressing and operand selection
    assign ram_raddr    = k_reg[ADDR_W-1:0];
    assign ram_waddr    = count_reg[ADDR_W-1:0];
    assign psq          = (2*PRIME_BITS)'(ram_rdata) * (2*PRIME_BITS)'(ram_rdata);
    assign k_at_end     = (k_reg == count_reg);
    assign init_phase   = (state_reg == S_INIT_RD) || (state_reg == S_INIT_CHK)
                          || (state_reg == S_INIT_DIV);
    assign div_dividend = init_phase ? DIV_W'(cand_reg) : DIV_W'(rem_reg);
    assign div_divisor  = ((state_reg == S_CHK) || (state_reg == S_INIT_CHK))
                          ? ram_rdata : p_reg;

    // next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        count_next = count_reg;
        cand_next  = cand_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        n_next     = n_reg;
        sigma_next = sigma_reg;
        geo_next   = geo_reg;
        p_next     = p_reg;
        sum_next   = sum_reg;
        perf_next  = perf_reg;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        mul_b      = geo_reg;
        unique case (state_reg)
            S_INIT_RD:
            begin
                if (k_at_end)
                begin
                    // no stored prime divides the candidate
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (cand_reg == CAND_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cand_next = cand_reg + PRIME_BITS'(1);
                        k_next    = '0;
                    end
                end
                else
                begin
                    state_next = S_INIT_CHK;
                end
            end
            S_INIT_CHK:
            begin
                p_next = ram_rdata;
                if (SQ_W'(psq) > SQ_W'(cand_reg))
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (cand_reg == CAND_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cand_next  = cand_reg + PRIME_BITS'(1);
                        k_next     = '0;
                        state_next = S_INIT_RD;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_INIT_DIV;
                end
            end
            S_INIT_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_INIT_RD;
                    if (div_stat.rem_zero)
                    begin
                        // composite candidate
                        if (cand_reg == CAND_LAST)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cand_next = cand_reg + PRIME_BITS'(1);
                            k_next    = '0;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + CNT_W'(1);
                    end
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = value;
                    rem_next   = value;
                    sigma_next = SIGMA_W'(1);
                    k_next     = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = k_at_end ? S_TAIL : S_CHK;
            end
            S_CHK:
            begin
                p_next   = ram_rdata;
                geo_next = GEO_W'(1);
                if (SQ_W'(psq) > SQ_W'(rem_reg))
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.rem_zero)
                    begin
                        // divide the prime out and extend its power sum
                        rem_next   = VALUE_BITS'(div_quo);
                        geo_next   = GEO_W'(geo_reg * GEO_W'(p_reg)) + GEO_W'(1);
                        state_next = S_DIVGO;
                    end
                    else if (geo_reg == GEO_W'(1))
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = S_RD;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    sigma_next = mul_prod;
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_RD;
                end
            end
            S_TAIL:
            begin
                // a leftover remainder of at least two counts as a prime
                if (rem_reg >= VALUE_BITS'(2))
                begin
                    mul_b      = GEO_W'(rem_reg) + GEO_W'(1);
                    mul_start  = 1'b1;
                    state_next = S_TMUL;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_TMUL:
            begin
                if (mul_done)
                begin
                    sigma_next = mul_prod;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                sum_next   = (CMP_W'(sigma_reg) > CMP_W'(SUM_MAX))
                             ? SUM_MAX : SUM_W'(sigma_reg);
                perf_next  = (n_reg != '0)
                             && (sigma_reg == SIGMA_W'({n_reg, 1'b0}));
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_RD;
            k_reg     <= '0;
            count_reg <= '0;
            cand_reg  <= PRIME_BITS'(2);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            count_reg <= count_next;
            cand_reg  <= cand_next;
            done_reg  <= done_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        n_reg     <= n_next;
        sigma_reg <= sigma_next;
        geo_reg   <= geo_next;
        p_reg     <= p_next;
        sum_reg   <= sum_next;
        perf_reg  <= perf_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign divisor_sum = sum_reg;
    assign is_perfect  = perf_reg;

    // result strobe only while a new request can be taken
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted request starts work at once
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // table walk never passes the stored primes
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= count_reg)
        else $error("table index beyond prime count");

    // prime count fits the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TAB_DEPTH))
        else $error("prime count exceeds table depth");

endmodule
